@@ sv/pcc_pkg.sv @@
// types, codes and lookup tables shared by the compression controller and its checker
package pcc_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_UP     = 3'd1,
        OP_DOWN   = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4,
        OP_TOGGLE = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_ERROR   = 2'd1,
        MODE_PUMPING = 2'd2,
        MODE_WORKING = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PROG_COMP    = 2'd0,
        PROG_PULSED  = 2'd1,
        PROG_VIB     = 2'd2,
        PROG_ROTATOR = 2'd3
    } t_program;

    typedef logic [17:0] t_elapsed;
    typedef logic [9:0]  t_pressure;
    typedef logic [9:0]  t_tps;
    typedef logic [2:0]  t_power;

    typedef struct packed {
        logic relief;
        logic inflate;
        logic pump;
    } t_act;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic       blink;
        t_power     power;
        t_program   prog;
        t_mode      mode;
        t_act       act;
    } t_result;

    localparam t_act ACT_OFF       = '{relief: 1'b0, inflate: 1'b0, pump: 1'b0};
    localparam t_act ACT_SAFE      = '{relief: 1'b1, inflate: 1'b1, pump: 1'b0};
    localparam t_act ACT_PUMP_FILL = '{relief: 1'b0, inflate: 1'b1, pump: 1'b1};

    localparam t_elapsed ELAPSED_MAX  = 18'h3FFFF;
    localparam logic [5:0] BLINK_LAST = 6'd59;
    localparam logic [2:0] PULSE_LAST = 3'd4;
    localparam logic [2:0] PULSE_OPEN_FROM = 3'd1;
    localparam t_power POWER_MAX      = 3'd4;
    localparam t_power POWER_RESET    = 3'd3;
    localparam t_tps TPS_RESET        = 10'd10;
    localparam logic [7:0] SECS_PUMP   = 8'd120;
    localparam logic [7:0] SECS_COMP   = 8'd100;
    localparam logic [7:0] SECS_PULSED = 8'd200;

    function automatic t_pressure press_limit(input t_power pw);
        case (pw)
            3'd0:    press_limit = 10'd120;
            3'd1:    press_limit = 10'd125;
            3'd2:    press_limit = 10'd130;
            3'd3:    press_limit = 10'd135;
            3'd4:    press_limit = 10'd140;
            default: press_limit = 10'd0;
        endcase
    endfunction

    function automatic logic [4:0] vib_inflate_secs(input t_power pw);
        case (pw)
            3'd0:    vib_inflate_secs = 5'd5;
            3'd1:    vib_inflate_secs = 5'd7;
            3'd2:    vib_inflate_secs = 5'd10;
            3'd3:    vib_inflate_secs = 5'd13;
            3'd4:    vib_inflate_secs = 5'd17;
            default: vib_inflate_secs = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] vib_relief_secs(input t_power pw);
        case (pw)
            3'd0:    vib_relief_secs = 5'd3;
            3'd1:    vib_relief_secs = 5'd2;
            3'd2:    vib_relief_secs = 5'd2;
            3'd3:    vib_relief_secs = 5'd1;
            3'd4:    vib_relief_secs = 5'd1;
            default: vib_relief_secs = 5'd1;
        endcase
    endfunction

endpackage

@@ sv/pneumatic_compression_controller_top.sv @@
// pneumatic compression controller: button and tick items in, actuator and status items out
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------------
//  s_axis   | in        | tuser op[2:0]; tdata pressure[9:0], zero pad to 16
//  m_axis   | out       | tdata pump, inflate, relief, mode[1:0], program[1:0],
//           |           |       power[2:0], blink, zero pad to 16
//  cfg      | in        | i_cfg_we / i_cfg_wdata: ticks_per_second[9:0]
//
//  one item per cycle while m_axis_tready accepts results; each item passes the input
//  register, the update logic and the result register before its result is offered
//  s_axis_tready stays high while the result register is empty or being drained
//  i_rst_n is synchronous, active low, and resets all state and both valid flags
module pneumatic_compression_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_wdata,     // ticks_per_second
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // pressure[9:0], zero pad
    input  logic [2:0]  s_axis_tuser,    // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // pump, inflate, relief, mode, program, power, blink
);

    logic                 r_in_valid;
    logic [2:0]           r_op;
    pcc_pkg::t_pressure   r_pressure;
    logic                 r_out_valid;
    pcc_pkg::t_result     r_out;
    pcc_pkg::t_result     n_out;
    logic                 advance;

    pcc_pkg::t_tps        r_tps;
    pcc_pkg::t_mode       r_mode, n_mode;
    pcc_pkg::t_program    r_program, n_program;
    pcc_pkg::t_power      r_power, n_power;
    pcc_pkg::t_elapsed    r_elapsed, n_elapsed;
    logic                 r_inflate_phase, n_inflate_phase;
    logic [2:0]           r_pulse, n_pulse;
    logic                 r_vib_step, n_vib_step;
    logic [5:0]           r_blink_cnt, n_blink_cnt;
    logic                 r_blink, n_blink;
    pcc_pkg::t_act        r_act, n_act;

    pcc_pkg::t_pressure   lim_press;
    pcc_pkg::t_elapsed    lim_pump, lim_comp, lim_vib;
    logic [4:0]           vib_secs;
    logic [2:0]           pulse_next;
    pcc_pkg::t_act        act_pulsed;
    logic                 running;
    logic                 do_start_stop;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= pcc_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_op       <= s_axis_tuser;
            r_pressure <= s_axis_tdata[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= pcc_pkg::MODE_WORKING;
            r_program       <= pcc_pkg::PROG_ROTATOR;
            r_power         <= pcc_pkg::POWER_RESET;
            r_elapsed       <= '0;
            r_inflate_phase <= 1'b0;
            r_pulse         <= '0;
            r_vib_step      <= 1'b1;
            r_blink_cnt     <= '0;
            r_blink         <= 1'b0;
            r_act           <= pcc_pkg::ACT_OFF;
        end else if (advance) begin
            r_mode          <= n_mode;
            r_program       <= n_program;
            r_power         <= n_power;
            r_elapsed       <= n_elapsed;
            r_inflate_phase <= n_inflate_phase;
            r_pulse         <= n_pulse;
            r_vib_step      <= n_vib_step;
            r_blink_cnt     <= n_blink_cnt;
            r_blink         <= n_blink;
            r_act           <= n_act;
        end
    end

    // limits: pressure, and durations in ticks
    assign lim_press  = pcc_pkg::press_limit(r_power);
    assign lim_pump   = pcc_pkg::t_elapsed'(pcc_pkg::SECS_PUMP) * pcc_pkg::t_elapsed'(r_tps);
    assign lim_comp   = (r_program == pcc_pkg::PROG_COMP)
                        ? pcc_pkg::t_elapsed'(pcc_pkg::SECS_COMP) * pcc_pkg::t_elapsed'(r_tps)
                        : pcc_pkg::t_elapsed'(pcc_pkg::SECS_PULSED) * pcc_pkg::t_elapsed'(r_tps);
    assign vib_secs   = r_vib_step ? pcc_pkg::vib_relief_secs(r_power)
                                   : pcc_pkg::vib_inflate_secs(r_power);
    assign lim_vib    = pcc_pkg::t_elapsed'(vib_secs) * pcc_pkg::t_elapsed'(r_tps);
    assign pulse_next = (r_pulse == pcc_pkg::PULSE_LAST) ? 3'd0 : r_pulse + 3'd1;
    assign act_pulsed = '{relief: 1'b0, inflate: (pulse_next > pcc_pkg::PULSE_OPEN_FROM),
                          pump: 1'b1};
    assign running    = r_mode inside {pcc_pkg::MODE_PUMPING, pcc_pkg::MODE_WORKING};

    always_comb begin
        n_mode          = r_mode;
        n_program       = r_program;
        n_power         = r_power;
        n_elapsed       = r_elapsed;
        n_inflate_phase = r_inflate_phase;
        n_pulse         = r_pulse;
        n_vib_step      = r_vib_step;
        n_blink_cnt     = r_blink_cnt;
        n_blink         = r_blink;
        n_act           = r_act;
        do_start_stop   = 1'b0;

        case (pcc_pkg::t_op'(r_op))
            pcc_pkg::OP_TICK: begin
                n_act = pcc_pkg::ACT_SAFE;
                if (r_mode == pcc_pkg::MODE_PUMPING
                    && r_program inside {pcc_pkg::PROG_COMP, pcc_pkg::PROG_PULSED}) begin
                    if (r_pressure < lim_press) begin
                        n_act = pcc_pkg::ACT_PUMP_FILL;
                    end else begin
                        n_mode          = pcc_pkg::MODE_WORKING;
                        n_elapsed       = '0;
                        n_inflate_phase = 1'b1;
                    end
                    if (n_elapsed > lim_pump) begin
                        n_mode    = pcc_pkg::MODE_ERROR;
                        n_elapsed = '0;
                    end
                end else if (r_mode == pcc_pkg::MODE_WORKING
                    && r_program inside {pcc_pkg::PROG_COMP, pcc_pkg::PROG_PULSED}) begin
                    if (r_inflate_phase) begin
                        if (r_pressure < lim_press) begin
                            if (r_program == pcc_pkg::PROG_COMP) begin
                                n_act = pcc_pkg::ACT_PUMP_FILL;
                            end else begin
                                n_pulse = pulse_next;
                                n_act   = act_pulsed;
                            end
                        end else begin
                            n_inflate_phase = 1'b0;
                            n_elapsed       = '0;
                        end
                    end else if (!(r_pressure > lim_press)) begin
                        n_inflate_phase = 1'b1;
                        n_elapsed       = '0;
                    end
                    if (n_elapsed > lim_comp) begin
                        n_mode    = pcc_pkg::MODE_ERROR;
                        n_elapsed = '0;
                    end
                end else if (r_mode == pcc_pkg::MODE_WORKING
                    && r_program == pcc_pkg::PROG_VIB) begin
                    if (!r_vib_step) begin
                        n_pulse = pulse_next;
                        n_act   = act_pulsed;
                    end
                    if (r_elapsed > lim_vib) begin
                        n_vib_step = !r_vib_step;
                        n_elapsed  = '0;
                    end
                end
                n_blink_cnt = (r_blink_cnt == pcc_pkg::BLINK_LAST) ? 6'd0 : r_blink_cnt + 6'd1;
                if (r_blink_cnt == pcc_pkg::BLINK_LAST) begin
                    n_blink = !r_blink;
                end
                if (n_elapsed < pcc_pkg::ELAPSED_MAX) begin
                    n_elapsed = n_elapsed + 18'd1;
                end
            end
            pcc_pkg::OP_UP: begin
                if (running) begin
                    if (r_power < pcc_pkg::POWER_MAX) begin
                        n_power = r_power + 3'd1;
                    end
                end else if (r_program != pcc_pkg::PROG_ROTATOR) begin
                    n_program = pcc_pkg::t_program'(r_program + 2'd1);
                end
            end
            pcc_pkg::OP_DOWN: begin
                if (running) begin
                    if (r_power != 3'd0) begin
                        n_power = r_power - 3'd1;
                    end
                end else if (r_program != pcc_pkg::PROG_COMP) begin
                    n_program = pcc_pkg::t_program'(r_program - 2'd1);
                end
            end
            pcc_pkg::OP_START: begin
                do_start_stop = (r_mode == pcc_pkg::MODE_READY);
            end
            pcc_pkg::OP_STOP: begin
                do_start_stop = (r_mode != pcc_pkg::MODE_READY);
            end
            pcc_pkg::OP_TOGGLE: begin
                do_start_stop = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_start_stop) begin
            n_elapsed  = '0;
            n_power    = '0;
            n_vib_step = 1'b0;
            if (r_mode == pcc_pkg::MODE_READY) begin
                n_mode = (r_program inside {pcc_pkg::PROG_COMP, pcc_pkg::PROG_PULSED})
                         ? pcc_pkg::MODE_PUMPING : pcc_pkg::MODE_WORKING;
            end else begin
                n_mode = pcc_pkg::MODE_READY;
            end
        end
    end

    always_comb begin
        n_out       = '0;
        n_out.act   = n_act;
        n_out.mode  = n_mode;
        n_out.prog  = n_program;
        n_out.power = n_power;
        n_out.blink = n_blink;
    end

endmodule

@@ sv/pcc_checker.sv @@
// port-level checks for the compression controller and their binding
module pcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    pcc_pkg::t_result res;

    assign res = m_axis_tdata;

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");

    a_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.power <= pcc_pkg::POWER_MAX)
        else $error("power level out of range");

    // initial pumping only runs a compression program
    a_pump_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.mode == pcc_pkg::MODE_PUMPING
        |-> res.prog == pcc_pkg::PROG_COMP || res.prog == pcc_pkg::PROG_PULSED)
        else $error("pumping with a non-compression program");

    // pump never runs against an open relief valve
    a_pump_relief: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.act.pump |-> !res.act.relief)
        else $error("pump on with relief open");

endmodule

bind pneumatic_compression_controller_top pcc_checker u_pcc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
